// ===== design/tdss_pkg.sv =====
// Package for the tridiagonal system solver.
// Holds the sequencer state type and the default sizing constants; depends on nothing.
package tdss_pkg;

   localparam int MAX_ROWS_DEF  = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_W        = 32;
   localparam int ROW_INDEX_W   = 6;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PIV_MUL,
      S_PIV_SUB,
      S_RHS_MUL,
      S_RHS_SUB,
      S_DIV_LOAD,
      S_DIV_RUN,
      S_DIV_DONE,
      S_WRITE,
      S_BS_READ,
      S_BS_MUL,
      S_BS_SUB,
      S_BS_OUT
   } state_type;

endpackage

// ===== design/tridiagonal_system_solver_unit.sv =====
// Top level of the tridiagonal system solver: Thomas algorithm in signed fixed point.
// Uses tdss_pkg for the state type and default constants.
//
// Each item is one row of the system. The shared restoring divider forms the modified super
// and right-hand-side terms one quotient bit per cycle. The modified terms live in one
// synchronous memory of MAX_ROWS words. After the row marked last, back substitution reads that
// memory from the last row down to row 0 and gives one result item per row, holding while the
// output is stalled. Input items are taken only while no row or back substitution is at work.
module tridiagonal_system_solver_unit #(
   parameter int MAX_ROWS  = tdss_pkg::MAX_ROWS_DEF,
   parameter int FRAC_BITS = tdss_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [tdss_pkg::WORD_W-1:0]     req_sub_coef,
   input  logic signed [tdss_pkg::WORD_W-1:0]     req_diag_coef,
   input  logic signed [tdss_pkg::WORD_W-1:0]     req_sup_coef,
   input  logic signed [tdss_pkg::WORD_W-1:0]     req_rhs_value,
   input  logic                                   req_last_row,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tdss_pkg::ROW_INDEX_W-1:0]       rsp_row_index,
   output logic signed [tdss_pkg::WORD_W-1:0]     rsp_solution_value,
   output logic                                   rsp_last_result,
   output logic                                   rsp_error_flag
);
   import tdss_pkg::*;

   localparam int IW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW   = $clog2(MAX_ROWS + 1);
   localparam int DW   = WORD_W + FRAC_BITS;
   localparam int CNTW = $clog2(DW);
   localparam int PW   = 2 * WORD_W;

   localparam logic signed [PW-1:0] ROUND_ADD = PW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PW-1:0] P_MAX     = PW'(64'sd2147483647);
   localparam logic signed [PW-1:0] P_MIN     = -(PW'(64'sd2147483648));
   localparam logic [DW-1:0]        Q_POS_LIM = DW'(64'd2147483647);
   localparam logic [DW-1:0]        Q_NEG_LIM = DW'(64'd2147483648);
   localparam logic signed [WORD_W-1:0] W_MAX = 32'sh7fffffff;
   localparam logic signed [WORD_W-1:0] W_MIN = 32'sh80000000;

   state_type state_ff, state_in;

   logic signed [WORD_W-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic                     last_ff, last_in;
   logic [CW-1:0]            row_count_ff, row_count_in;
   logic signed [WORD_W-1:0] prev_sup_ff, prev_sup_in, prev_rhs_ff, prev_rhs_in;
   logic                     err_ff, err_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic signed [WORD_W-1:0] piv_ff, piv_in, dnum_ff, dnum_in;
   logic                     div_sel_ff, div_sel_in;
   logic [DW-1:0]            dvd_ff, dvd_in;
   logic [WORD_W-1:0]        rem_ff, rem_in, dvs_ff, dvs_in;
   logic                     neg_ff, neg_in;
   logic [CNTW-1:0]          cnt_ff, cnt_in;
   logic signed [WORD_W-1:0] cm_ff, cm_in, dm_ff, dm_in;
   logic [IW-1:0]            bs_idx_ff, bs_idx_in;
   logic                     bs_first_ff, bs_first_in;
   logic signed [WORD_W-1:0] x_ff, x_in;
   logic [PW-1:0]            rd_ff;
   logic [PW-1:0]            mem_ff [MAX_ROWS];

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ROW_INDEX_W-1:0]          rsp_row_ff, rsp_row_in;
   logic signed [WORD_W-1:0]        rsp_sol_ff, rsp_sol_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic                            rsp_err_ff, rsp_err_in;

   logic                     req_take, out_load, full;
   logic signed [WORD_W-1:0] mul_x, mul_y, sub_x, rnd_val, diff_val, div_num, quo_val;
   logic signed [PW-1:0]     rnd_sum, rnd_shift;
   logic                     rnd_sat, diff_sat, quo_sat;
   logic signed [WORD_W:0]   diff_wide;
   logic [WORD_W:0]          trial;
   logic [WORD_W-1:0]        num_mag, piv_mag;
   logic [31:0]              idx_wide;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_load = (state_ff == S_BS_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign full = (row_count_ff >= CW'(MAX_ROWS));

   always_comb begin
      unique case (state_ff)
         S_PIV_MUL: begin
            mul_x = prev_sup_ff;
            mul_y = a_ff;
         end
         S_RHS_MUL: begin
            mul_x = prev_rhs_ff;
            mul_y = a_ff;
         end
         default: begin
            mul_x = rd_ff[PW-1:WORD_W];
            mul_y = x_ff;
         end
      endcase
      prod_in = PW'(mul_x) * PW'(mul_y);

      rnd_sum = prod_ff + ROUND_ADD;
      rnd_shift = rnd_sum >>> FRAC_BITS;
      rnd_sat = (rnd_shift > P_MAX) || (rnd_shift < P_MIN);
      if (rnd_shift > P_MAX) begin
         rnd_val = W_MAX;
      end else if (rnd_shift < P_MIN) begin
         rnd_val = W_MIN;
      end else begin
         rnd_val = rnd_shift[WORD_W-1:0];
      end

      unique case (state_ff)
         S_PIV_SUB: sub_x = b_ff;
         S_RHS_SUB: sub_x = d_ff;
         default:   sub_x = rd_ff[WORD_W-1:0];
      endcase
      diff_wide = {sub_x[WORD_W-1], sub_x} - {rnd_val[WORD_W-1], rnd_val};
      diff_sat = (diff_wide[WORD_W] != diff_wide[WORD_W-1]);
      if (!diff_sat) begin
         diff_val = diff_wide[WORD_W-1:0];
      end else if (diff_wide[WORD_W]) begin
         diff_val = W_MIN;
      end else begin
         diff_val = W_MAX;
      end

      div_num = div_sel_ff ? dnum_ff : c_ff;
      num_mag = div_num[WORD_W-1] ? WORD_W'(-div_num) : WORD_W'(div_num);
      piv_mag = piv_ff[WORD_W-1] ? WORD_W'(-piv_ff) : WORD_W'(piv_ff);
      trial = {rem_ff, dvd_ff[DW-1]};

      if (neg_ff) begin
         quo_sat = dvd_ff > Q_NEG_LIM;
         quo_val = quo_sat ? W_MIN : -$signed(dvd_ff[WORD_W-1:0]);
      end else begin
         quo_sat = dvd_ff > Q_POS_LIM;
         quo_val = quo_sat ? W_MAX : $signed(dvd_ff[WORD_W-1:0]);
      end

      idx_wide = 32'(bs_idx_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (full) begin
                  state_in = req_last_row ? S_BS_READ : S_IDLE;
               end else if (row_count_ff == '0) begin
                  state_in = S_DIV_LOAD;
               end else begin
                  state_in = S_PIV_MUL;
               end
            end
         end
         S_PIV_MUL:  state_in = S_PIV_SUB;
         S_PIV_SUB:  state_in = S_RHS_MUL;
         S_RHS_MUL:  state_in = S_RHS_SUB;
         S_RHS_SUB:  state_in = S_DIV_LOAD;
         S_DIV_LOAD: begin
            if (piv_ff != '0) begin
               state_in = S_DIV_RUN;
            end else begin
               state_in = div_sel_ff ? S_WRITE : S_DIV_LOAD;
            end
         end
         S_DIV_RUN:  state_in = (cnt_ff == '0) ? S_DIV_DONE : S_DIV_RUN;
         S_DIV_DONE: state_in = div_sel_ff ? S_WRITE : S_DIV_LOAD;
         S_WRITE:    state_in = last_ff ? S_BS_READ : S_IDLE;
         S_BS_READ:  state_in = S_BS_MUL;
         S_BS_MUL:   state_in = bs_first_ff ? S_BS_OUT : S_BS_SUB;
         S_BS_SUB:   state_in = S_BS_OUT;
         S_BS_OUT: begin
            if (out_load) begin
               state_in = (bs_idx_ff == '0) ? S_IDLE : S_BS_READ;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      last_in = last_ff;
      row_count_in = row_count_ff;
      prev_sup_in = prev_sup_ff;
      prev_rhs_in = prev_rhs_ff;
      err_in = err_ff;
      piv_in = piv_ff;
      dnum_in = dnum_ff;
      div_sel_in = div_sel_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      cm_in = cm_ff;
      dm_in = dm_ff;
      bs_idx_in = bs_idx_ff;
      bs_first_in = bs_first_ff;
      x_in = x_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in = rsp_row_ff;
      rsp_sol_in = rsp_sol_ff;
      rsp_last_in = rsp_last_ff;
      rsp_err_in = rsp_err_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               a_in = req_sub_coef;
               b_in = req_diag_coef;
               c_in = req_sup_coef;
               d_in = req_rhs_value;
               last_in = req_last_row;
               piv_in = req_diag_coef;
               dnum_in = req_rhs_value;
               div_sel_in = 1'b0;
               bs_first_in = 1'b1;
               if (row_count_ff == '0) begin
                  err_in = 1'b0;
               end
               if (full) begin
                  err_in = 1'b1;
                  bs_idx_in = IW'(MAX_ROWS - 1);
               end
            end
         end
         S_PIV_SUB: begin
            piv_in = diff_val;
            err_in = err_ff || rnd_sat || diff_sat;
         end
         S_RHS_SUB: begin
            dnum_in = diff_val;
            err_in = err_ff || rnd_sat || diff_sat;
         end
         S_DIV_LOAD: begin
            dvd_in = {num_mag, {FRAC_BITS{1'b0}}};
            rem_in = '0;
            dvs_in = piv_mag;
            neg_in = div_num[WORD_W-1] ^ piv_ff[WORD_W-1];
            cnt_in = CNTW'(DW - 1);
            if (piv_ff == '0) begin
               err_in = 1'b1;
               div_sel_in = 1'b1;
               if (div_sel_ff) begin
                  dm_in = '0;
               end else begin
                  cm_in = '0;
               end
            end
         end
         S_DIV_RUN: begin
            cnt_in = cnt_ff - CNTW'(1);
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in = WORD_W'(trial - {1'b0, dvs_ff});
               dvd_in = {dvd_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = trial[WORD_W-1:0];
               dvd_in = {dvd_ff[DW-2:0], 1'b0};
            end
         end
         S_DIV_DONE: begin
            err_in = err_ff || quo_sat;
            div_sel_in = 1'b1;
            if (div_sel_ff) begin
               dm_in = quo_val;
            end else begin
               cm_in = quo_val;
            end
         end
         S_WRITE: begin
            prev_sup_in = cm_ff;
            prev_rhs_in = dm_ff;
            bs_idx_in = row_count_ff[IW-1:0];
            row_count_in = row_count_ff + CW'(1);
         end
         S_BS_MUL: begin
            if (bs_first_ff) begin
               x_in = rd_ff[WORD_W-1:0];
            end
         end
         S_BS_SUB: begin
            x_in = diff_val;
            err_in = err_ff || rnd_sat || diff_sat;
         end
         S_BS_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_row_in = idx_wide[ROW_INDEX_W-1:0];
               rsp_sol_in = x_ff;
               rsp_last_in = (bs_idx_ff == '0);
               rsp_err_in = err_ff;
               bs_first_in = 1'b0;
               bs_idx_in = bs_idx_ff - IW'(1);
               if (bs_idx_ff == '0) begin
                  row_count_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE) begin
         mem_ff[row_count_ff[IW-1:0]] <= {cm_ff, dm_ff};
      end
      rd_ff <= mem_ff[bs_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_count_ff <= '0;
         prev_sup_ff <= '0;
         prev_rhs_ff <= '0;
         err_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_sel_ff <= 1'b0;
         bs_first_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         row_count_ff <= row_count_in;
         prev_sup_ff <= prev_sup_in;
         prev_rhs_ff <= prev_rhs_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         div_sel_ff <= div_sel_in;
         bs_first_ff <= bs_first_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      last_ff <= last_in;
      prod_ff <= prod_in;
      piv_ff <= piv_in;
      dnum_ff <= dnum_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      cm_ff <= cm_in;
      dm_ff <= dm_in;
      bs_idx_ff <= bs_idx_in;
      x_ff <= x_in;
      rsp_row_ff <= rsp_row_in;
      rsp_sol_ff <= rsp_sol_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_solution_value = rsp_sol_ff;
   assign rsp_last_result = rsp_last_ff;
   assign rsp_error_flag = rsp_err_ff;

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV_RUN |-> dvs_ff != '0)
      else $error("divider running with a zero divisor");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= CW'(MAX_ROWS))
      else $error("row count beyond capacity");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (out_load && bs_idx_ff == '0) |=> (row_count_ff == '0 && state_ff == S_IDLE))
      else $error("system not closed after the row 0 item");

endmodule

// ===== dv/tridiagonal_system_solver_unit_tb.sv =====
// Testbench for tridiagonal_system_solver_unit: rows go in, solution items are checked.
// A clocked driver and monitor surround a predictor of the Thomas elimination; uses tdss_pkg.
module tridiagonal_system_solver_unit_tb;
   import tdss_pkg::*;

   localparam int NROWS = MAX_ROWS_DEF;
   localparam int FB    = FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic signed [31:0] a, b, c, d;
      logic               last;
   } row_type;

   typedef struct {
      logic [5:0]         idx;
      logic signed [31:0] x;
      logic               fin;
      logic               err;
   } soln_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_last_row = 0, rsp_stall = 0;
   logic signed [31:0] req_sub_coef = 0, req_diag_coef = 0, req_sup_coef = 0, req_rhs_value = 0;
   logic req_stall, rsp_valid, rsp_last_result, rsp_error_flag;
   logic [5:0] rsp_row_index;
   logic signed [31:0] rsp_solution_value;

   tridiagonal_system_solver_unit i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   row_type  pending_rows[$];
   soln_type expected_solns[$];
   int    send_idle_pct = 0, stall_pct = 0, hold_cycles = 0;
   int    mismatches = 0, solns_seen = 0, systems_seen = 0, idle_cycles = 0;
   logic  feeding_done = 0;

   // Predictor state.
   logic signed [31:0] cp_store[NROWS], dp_store[NROWS], cp_prev, dp_prev;
   int   rows_held = 0;
   logic err_sticky = 0;

   function automatic logic signed [31:0] clamp(input logic signed [65:0] v);
      if (v > 66'sh7FFFFFFF) begin
         err_sticky = 1;
         return 32'sh7FFFFFFF;
      end
      if (v < -66'sh80000000) begin
         err_sticky = 1;
         return -32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] qmul(input logic signed [31:0] x, y);
      logic signed [65:0] p;
      p = (66'(x) * 66'(y) + (66'sd1 <<< (FB - 1))) >>> FB;
      return clamp(p);
   endfunction

   function automatic logic signed [31:0] qsub(input logic signed [31:0] x, y);
      return clamp(66'(x) - 66'(y));
   endfunction

   function automatic logic signed [31:0] qdiv(input logic signed [31:0] n, den);
      logic signed [65:0] q;
      if (den == 0) begin
         err_sticky = 1;
         return 0;
      end
      q = (66'(n) <<< FB) / 66'(den);
      return clamp(q);
   endfunction

   function automatic void eliminate_row(input row_type r);
      logic signed [31:0] cm, dm, piv, x;
      soln_type s;
      if (rows_held == 0) err_sticky = 0;
      if (rows_held >= NROWS) begin
         err_sticky = 1;
      end else begin
         if (rows_held == 0) begin
            cm = qdiv(r.c, r.b);
            dm = qdiv(r.d, r.b);
         end else begin
            piv = qsub(r.b, qmul(cp_prev, r.a));
            cm  = qdiv(r.c, piv);
            dm  = qdiv(qsub(r.d, qmul(dp_prev, r.a)), piv);
         end
         cp_store[rows_held] = cm;
         dp_store[rows_held] = dm;
         cp_prev = cm;
         dp_prev = dm;
         rows_held++;
      end
      if (!r.last) return;
      x = dp_store[rows_held - 1];
      for (int i = rows_held - 1; i >= 0; i--) begin
         if (i != rows_held - 1) x = qsub(dp_store[i], qmul(cp_store[i], x));
         s.idx = i[5:0];
         s.x   = x;
         s.fin = (i == 0);
         s.err = err_sticky;
         expected_solns.push_back(s);
      end
      rows_held = 0;
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || !req_stall) begin
         if (pending_rows.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            row_type r;
            r = pending_rows.pop_front();
            req_sub_coef  <= r.a;
            req_diag_coef <= r.b;
            req_sup_coef  <= r.c;
            req_rhs_value <= r.d;
            req_last_row  <= r.last;
            req_valid     <= 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // Accepted rows feed the predictor.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         row_type r;
         r.a = req_sub_coef;
         r.b = req_diag_coef;
         r.c = req_sup_coef;
         r.d = req_rhs_value;
         r.last = req_last_row;
         eliminate_row(r);
      end
   end

   // Receiver stall and monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall   <= 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
         if (rsp_valid && !rsp_stall) begin
            solns_seen++;
            if (expected_solns.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result item: row %0d value %0d", rsp_row_index,
                           rsp_solution_value);
            end else begin
               soln_type e;
               e = expected_solns.pop_front();
               if (e.idx !== rsp_row_index || e.x !== rsp_solution_value ||
                   e.fin !== rsp_last_result || e.err !== rsp_error_flag) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected row %0d x %0d last %0b err %0b, ",
                               "got row %0d x %0d last %0b err %0b"},
                              e.idx, e.x, e.fin, e.err, rsp_row_index, rsp_solution_value,
                              rsp_last_result, rsp_error_flag);
               end
               if (e.fin) systems_seen++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || feeding_done)
         idle_cycles <= 0;
      else if (hold_cycles == 0)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d result items outstanding", expected_solns.size());
         $display("[tridiagonal_system_solver_unit] ERROR");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_word(input int kind);
      case (kind)
         0: return $urandom();
         1: return 32'sh7FFFFFFF;
         2: return -32'sh80000000;
         3: return 0;
         default: return $signed($urandom_range(2 << FB)) - (1 << FB);
      endcase
   endfunction

   function automatic row_type make_row(input logic signed [31:0] a, b, c, d, input logic last);
      row_type r;
      r.a = a; r.b = b; r.c = c; r.d = d; r.last = last;
      return r;
   endfunction

   // A well-conditioned system (dominant diagonal, small random off-diagonals), or random words if noisy.
   function automatic void push_system(input int n, input bit noisy);
      for (int i = 0; i < n; i++) begin
         logic signed [31:0] a, c, b, d;
         a = $signed($urandom_range(2 << FB)) - (1 << FB);
         c = $signed($urandom_range(2 << FB)) - (1 << FB);
         b = $signed($urandom_range(6 << FB, 3 << FB));
         if ($urandom_range(1)) b = -b;
         d = $signed($urandom_range(200 << FB)) - (100 << FB);
         if (noisy) begin
            a = rand_word($urandom_range(4));
            b = rand_word($urandom_range(4));
            c = rand_word($urandom_range(4));
            d = rand_word($urandom_range(4));
         end
         pending_rows.push_back(make_row(a, b, c, d, i == n - 1));
      end
   endfunction

   task automatic drain();
      while (pending_rows.size() > 0 || req_valid || expected_solns.size() > 0 ||
             rows_held != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int total;
      repeat (10) @(posedge clock);
      reset <= 0;

      // Directed: single rows and two-row systems, zero pivot, extreme words, saturation, then a small system.
      pending_rows.push_back(make_row(5, 2 << FB, 7, 6 << FB, 1));
      pending_rows.push_back(make_row(-1, 0, 1, 1 << FB, 1));
      pending_rows.push_back(make_row(32'sh7FFFFFFF, 1, -32'sh80000000, 32'sh7FFFFFFF, 1));
      pending_rows.push_back(make_row(-32'sh80000000, -1, 32'sh7FFFFFFF, -32'sh80000000, 1));
      pending_rows.push_back(make_row(0, 1 << FB, 1 << FB, 1 << FB, 0));
      pending_rows.push_back(make_row(1 << FB, 1 << FB, 0, 2 << FB, 1));
      pending_rows.push_back(make_row(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                      32'sh7FFFFFFF, 0));
      pending_rows.push_back(make_row(-32'sh80000000, -32'sh80000000, 0, -32'sh80000000, 1));
      push_system(4, 0);
      drain();

      // Row overflow: one row beyond capacity, then a recovery system.
      push_system(NROWS + 1, 0);
      push_system(3, 0);
      send_idle_pct = 0;
      drain();

      total = 0;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 60 : 18) : 0;
         stall_pct     = (phase == 2) ? 60 : ((phase == 3) ? 18 : 0);
         if (phase == 1) hold_cycles = 2000;
         while (total < 50 * (phase + 1)) begin
            int n;
            n = $urandom_range(8, 1);
            push_system(n, $urandom_range(4) == 0);
            total += n;
         end
         drain();
      end

      feeding_done = 1;
      $display("covered %0d solution items over %0d systems, incl. zero pivots, overflow",
               solns_seen, systems_seen);
      $display("and saturation, under sender gaps, receiver stalls and a long hold-off");
      if (mismatches == 0) begin
         $display("[tridiagonal_system_solver_unit] OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[tridiagonal_system_solver_unit] ERROR");
      end
      $finish;
   end
endmodule

// ===== tridiagonal_system_solver_unit.f =====
design/tdss_pkg.sv
design/tridiagonal_system_solver_unit.sv
dv/tridiagonal_system_solver_unit_tb.sv
